FILE: design/offboard_engage_sequencer_defines.svh
// ----------------------------------------------------------------------------
// offboard engage sequencer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef OFFBOARD_ENGAGE_SEQUENCER_DEFINES_SVH
`define OFFBOARD_ENGAGE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("offboard engage sequencer check failed");

// next-cycle implication, disabled during reset
`define OES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("offboard engage sequencer check failed");

`endif

FILE: design/oes_pkg.sv
// ----------------------------------------------------------------------------
// oes_pkg
// types, codes and helpers of the offboard engage sequencer
// ----------------------------------------------------------------------------
package oes_pkg;

	localparam int AgeW = 10;
	localparam int CntW = 8;
	localparam logic [AgeW-1:0] AGE_MAX = '1;
	localparam logic [CntW-1:0] CNT_MAX = '1;
	localparam logic [4:0] NAV_OFFBOARD = 5'd14;

	// register indexes
	localparam logic [1:0] REG_ENGAGE_TICKS  = 2'd0;
	localparam logic [1:0] REG_MODE_LIMIT    = 2'd1;
	localparam logic [1:0] REG_HEALTH_LIMIT  = 2'd2;
	localparam logic [1:0] REG_FRESH_LIMIT   = 2'd3;

	localparam logic [CntW-1:0] ENGAGE_TICKS_RST = 8'd10;
	localparam logic [CntW-1:0] MODE_LIMIT_RST   = 8'd20;
	localparam logic [CntW-1:0] HEALTH_LIMIT_RST = 8'd100;
	localparam logic [AgeW-1:0] FRESH_LIMIT_RST  = 10'd20;

	typedef enum logic [1:0] {
		CMD_NONE     = 2'd0,
		CMD_OFFBOARD = 2'd1,
		CMD_LOITER   = 2'd2,
		CMD_ARM      = 2'd3
	} cmd_t;

	localparam logic [1:0] SP_NONE    = 2'd0;
	localparam logic [1:0] SP_YAW     = 2'd1;
	localparam logic [1:0] SP_PLANNER = 2'd2;

	localparam logic [1:0] PHC_STREAM = 2'd0;
	localparam logic [1:0] PHC_MODE   = 2'd1;
	localparam logic [1:0] PHC_HEALTH = 2'd2;

	typedef enum logic [2:0] {
		PH_STREAM = 3'b001,
		PH_MODE   = 3'b010,
		PH_HEALTH = 3'b100
	} phase_t;

	typedef struct packed {
		logic       killed;
		logic       inhibited;
		logic       planner_timed_out;
		logic       status_arrived;
		logic [4:0] nav_mode;
		logic       status_failsafe;
		logic       position_arrived;
		logic       horiz_valid;
		logic       z_valid;
	} in_word_t;

	typedef struct packed {
		cmd_t       command;
		logic       heartbeat_sent;
		logic [1:0] setpoint_kind;
		logic       ctl_engaged;
		logic       armed_flag;
		logic [1:0] engage_phase;
		logic [9:0] heartbeat_age;
	} out_word_t;

	function automatic logic [AgeW-1:0] age_inc(input logic [AgeW-1:0] a);
		return (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
	endfunction

	function automatic logic [CntW-1:0] cnt_inc(input logic [CntW-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	function automatic logic [1:0] phase_code(input phase_t p);
		logic [1:0] code;
		case (p)
			PH_MODE:   code = PHC_MODE;
			PH_HEALTH: code = PHC_HEALTH;
			default:   code = PHC_STREAM;
		endcase
		return code;
	endfunction

endpackage

FILE: design/offboard_engage_sequencer.sv
// ----------------------------------------------------------------------------
// offboard_engage_sequencer
// control tick sequencer: report freshness, engage phases, arm and failsafe
// ----------------------------------------------------------------------------
// One input word is one control tick carrying the kill, inhibit and planner
// timeout flags plus any status or position report that came with it. Every
// tick yields exactly one result word: command code, heartbeat and setpoint
// flags, active and armed flags, engage phase and heartbeat age.
// Both channels are valid/ready. A word is taken into an input register,
// the next state and the result are formed in one pass of flag logic and
// saturating counters, and the result lands in an output register.
// A word accepted into the input register has its result written to the output
// register when it advances. Throughput is one word per cycle while the
// receiver does not stall, since the sequence state updates once per word.
// When the receiver stalls, the result register holds, the input register
// fills and input ready drops; no word is lost or repeated.
// Reset clears the sequence, report ages go to 1023 and the four registers
// take their default limits (10, 20, 100, 20). The user writes registers via
// cfg_we / cfg_index / cfg_wdata only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module offboard_engage_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  oes_pkg::in_word_t item,
	output logic              result_valid,
	input  logic              result_ready,
	output oes_pkg::out_word_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [9:0]        cfg_wdata
);
	import oes_pkg::*;

	logic [CntW-1:0] engage_ticks_q, mode_limit_q, health_limit_q;
	logic [AgeW-1:0] fresh_limit_q;

	logic     item_valid_s1;
	in_word_t item_s1;
	logic     advance;

	phase_t          phase_q, phase_n;
	logic [CntW-1:0] engage_cnt_q, engage_cnt_n, ticks_q, ticks_n, ticks_inc;
	logic            active_q, active_n, armed_q, armed_n;
	logic            st_seen_q, st_seen_n, fs_q, fs_n;
	logic [4:0]      nav_q, nav_n;
	logic [AgeW-1:0] st_age_q, st_age_n, pos_age_q, pos_age_n, beat_age_q, beat_age_n;
	logic            pos_seen_q, pos_seen_n;
	logic [1:0]      pos_valid_q, pos_valid_n;
	logic            st_fresh, veh_ready, beat;
	cmd_t            cmd;
	logic [1:0]      sp_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engage_ticks_q <= ENGAGE_TICKS_RST;
			mode_limit_q   <= MODE_LIMIT_RST;
			health_limit_q <= HEALTH_LIMIT_RST;
			fresh_limit_q  <= FRESH_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENGAGE_TICKS: engage_ticks_q <= cfg_wdata[CntW-1:0];
				REG_MODE_LIMIT:   mode_limit_q   <= cfg_wdata[CntW-1:0];
				REG_HEALTH_LIMIT: health_limit_q <= cfg_wdata[CntW-1:0];
				REG_FRESH_LIMIT:  fresh_limit_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance    = item_valid_s1 && (!result_valid || result_ready);
	assign item_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// next state of one tick, reports latched before they are judged
	always_comb begin
		phase_n      = phase_q;
		engage_cnt_n = engage_cnt_q;
		ticks_n      = ticks_q;
		active_n     = active_q;
		armed_n      = armed_q;
		cmd          = CMD_NONE;
		sp_kind      = SP_NONE;
		beat         = 1'b0;

		if (item_s1.status_arrived) begin
			st_seen_n = 1'b1;
			st_age_n  = '0;
			nav_n     = item_s1.nav_mode;
			fs_n      = item_s1.status_failsafe;
		end else begin
			st_seen_n = st_seen_q;
			st_age_n  = age_inc(st_age_q);
			nav_n     = nav_q;
			fs_n      = fs_q;
		end
		if (item_s1.position_arrived) begin
			pos_seen_n  = 1'b1;
			pos_age_n   = '0;
			pos_valid_n = {item_s1.z_valid, item_s1.horiz_valid};
		end else begin
			pos_seen_n  = pos_seen_q;
			pos_age_n   = age_inc(pos_age_q);
			pos_valid_n = pos_valid_q;
		end
		beat_age_n = age_inc(beat_age_q);

		st_fresh  = st_seen_n && (st_age_n <= fresh_limit_q);
		veh_ready = st_fresh && pos_seen_n && (pos_age_n <= fresh_limit_q)
			&& (pos_valid_n == 2'b11) && !fs_n;
		ticks_inc = cnt_inc(ticks_q);

		if (item_s1.killed || item_s1.inhibited || item_s1.planner_timed_out) begin
			if (!item_s1.killed && !item_s1.inhibited && active_q) begin
				cmd = CMD_LOITER;
			end
			active_n     = 1'b0;
			engage_cnt_n = '0;
			phase_n      = PH_STREAM;
			ticks_n      = '0;
		end else if (!active_q) begin
			beat    = 1'b1;
			sp_kind = SP_YAW;
			ticks_n = ticks_inc;
			case (phase_q)
				PH_MODE: begin
					if (st_fresh && nav_n == NAV_OFFBOARD) begin
						phase_n = PH_HEALTH;
						ticks_n = '0;
					end else if (ticks_inc >= mode_limit_q) begin
						engage_cnt_n = '0;
						phase_n      = PH_STREAM;
						ticks_n      = '0;
					end
				end
				PH_HEALTH: begin
					if (veh_ready) begin
						cmd      = CMD_ARM;
						active_n = 1'b1;
						armed_n  = 1'b1;
					end else if (ticks_inc >= health_limit_q) begin
						engage_cnt_n = '0;
						phase_n      = PH_STREAM;
						ticks_n      = '0;
					end
				end
				default: begin
					phase_n      = PH_STREAM;
					engage_cnt_n = cnt_inc(engage_cnt_q);
					if (engage_cnt_n >= engage_ticks_q) begin
						cmd     = CMD_OFFBOARD;
						phase_n = PH_MODE;
						ticks_n = '0;
					end
				end
			endcase
		end else begin
			beat    = 1'b1;
			sp_kind = SP_PLANNER;
		end

		if (beat) begin
			beat_age_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STREAM;
			engage_cnt_q <= '0;
			ticks_q      <= '0;
			active_q     <= 1'b0;
			armed_q      <= 1'b0;
			st_seen_q    <= 1'b0;
			st_age_q     <= AGE_MAX;
			nav_q        <= '0;
			fs_q         <= 1'b0;
			pos_seen_q   <= 1'b0;
			pos_age_q    <= AGE_MAX;
			pos_valid_q  <= '0;
			beat_age_q   <= AGE_MAX;
		end else if (advance) begin
			phase_q      <= phase_n;
			engage_cnt_q <= engage_cnt_n;
			ticks_q      <= ticks_n;
			active_q     <= active_n;
			armed_q      <= armed_n;
			st_seen_q    <= st_seen_n;
			st_age_q     <= st_age_n;
			nav_q        <= nav_n;
			fs_q         <= fs_n;
			pos_seen_q   <= pos_seen_n;
			pos_age_q    <= pos_age_n;
			pos_valid_q  <= pos_valid_n;
			beat_age_q   <= beat_age_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.command         <= cmd;
			result.heartbeat_sent  <= beat;
			result.setpoint_kind   <= sp_kind;
			result.ctl_engaged     <= active_n;
			result.armed_flag      <= armed_n;
			result.engage_phase    <= phase_code(phase_n);
			result.heartbeat_age   <= beat_age_n;
		end
	end

endmodule

FILE: design/oes_checker.sv
// ----------------------------------------------------------------------------
// oes_checker
// port-level checks of the offboard engage sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "offboard_engage_sequencer_defines.svh"

module oes_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input oes_pkg::out_word_t result
);
	import oes_pkg::*;

	// a stalled result word holds
	`OES_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// heartbeat age reads zero exactly on heartbeat ticks
	`OES_ASSERT_IMPL(a_beat_age, clk, arst_n, result_valid, result.heartbeat_sent == (result.heartbeat_age == 10'd0))

	// setpoints go out only alongside a heartbeat
	`OES_ASSERT_IMPL(a_sp_beat, clk, arst_n, result_valid, (result.setpoint_kind != SP_NONE) == result.heartbeat_sent)

	// arm leaves the block active, armed and in the health phase
	`OES_ASSERT_IMPL(a_arm_state, clk, arst_n, result_valid && result.command == CMD_ARM, result.ctl_engaged && result.armed_flag && result.engage_phase == PHC_HEALTH)

	// the mode request moves an inactive block into mode confirm
	`OES_ASSERT_IMPL(a_mode_req, clk, arst_n, result_valid && result.command == CMD_OFFBOARD, !result.ctl_engaged && result.engage_phase == PHC_MODE)

endmodule

bind offboard_engage_sequencer oes_checker u_oes_checker (.*);
